// ----- rtl/gpfo_pkg.sv -----
// ----------------------------------------------------------------------------
// gpfo_pkg
// Shared types, constants and arithmetic helpers for the fixed-operand
// geometric product block.
// ----------------------------------------------------------------------------
package gpfo_pkg;

  // Blade layout: eight blades indexed by axis bit masks
  localparam int BLADES        = 8;
  localparam int BLADE_BITS    = 3;
  localparam int MAX_DIMENSION = 3;

  // Fixed-point format of coefficients
  localparam int FRAC_BITS = 12;

  // Accumulator and pipeline shape
  localparam int ACC_W       = 64;
  localparam int ACC_STAGES  = 4;   // two terms folded in per stage
  localparam int LANE_STAGES = ACC_STAGES + 1;
  localparam int PIPE_STAGES = LANE_STAGES + 1;

  // Configuration port
  localparam int REG_W  = 64;
  localparam int ADDR_W = 6;

  localparam logic [2:0] REG_DIMENSION = 3'd0;
  localparam logic [2:0] REG_NEG_AXES  = 3'd1;
  localparam logic [2:0] REG_ON_LEFT   = 3'd2;
  localparam logic [2:0] REG_OP_LOW    = 3'd3;
  localparam logic [2:0] REG_OP_HIGH   = 3'd4;

  typedef logic signed [ACC_W-1:0] acc_t;

  localparam acc_t ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam acc_t ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam acc_t ROUND_HALF = acc_t'(64'd1 << (FRAC_BITS - 1));

  // Settings that every lane sees
  typedef struct packed {
    logic [BLADE_BITS-1:0] neg_axes;
    logic                  on_left;
  } lane_cfg_t;

  // Add with clamping at the accumulator limits
  function automatic acc_t sat_add(acc_t a, acc_t b);
    logic [ACC_W:0] sum;
    sum = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    if (sum[ACC_W] != sum[ACC_W-1]) begin
      sat_add = sum[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      sat_add = sum[ACC_W-1:0];
    end
  endfunction

  // Sign of the term (left blade a) * (right blade b): 1 means negate.
  // Reordering parity plus one flip for each shared axis squaring to -1.
  function automatic logic term_negative(logic [BLADE_BITS-1:0] a,
                                         logic [BLADE_BITS-1:0] b,
                                         logic [BLADE_BITS-1:0] neg);
    logic                  flips;
    logic [BLADE_BITS-1:0] below;
    flips = 1'b0;
    for (int i = 0; i < BLADE_BITS; i++) begin
      below = (BLADE_BITS'(1) << i) - BLADE_BITS'(1);
      if (a[i]) begin
        flips = flips ^ (^(b & below)) ^ (b[i] & neg[i]);
      end
    end
    term_negative = flips;
  endfunction

endpackage

// ----- rtl/gpfo_lane.sv -----
// ----------------------------------------------------------------------------
// gpfo_lane
// One output blade: forms the eight signed products that land on this blade
// and folds them into a saturating accumulator, two per stage.
// ----------------------------------------------------------------------------
module gpfo_lane #(
  parameter int COEFF_WIDTH = 16,
  parameter int LANE        = 0
) (
  input  logic                          clk,
  input  logic [gpfo_pkg::LANE_STAGES-1:0] load,
  input  gpfo_pkg::lane_cfg_t           cfg,
  input  logic signed [COEFF_WIDTH-1:0] x  [gpfo_pkg::BLADES],
  input  logic signed [COEFF_WIDTH-1:0] op [gpfo_pkg::BLADES],
  output gpfo_pkg::acc_t                acc
);

  localparam int PROD_W = 2 * COEFF_WIDTH + 1;
  localparam logic [gpfo_pkg::BLADE_BITS-1:0] LANE_IDX = gpfo_pkg::BLADE_BITS'(LANE);

  logic signed [PROD_W-1:0] prod_q [gpfo_pkg::ACC_STAGES][gpfo_pkg::BLADES];
  gpfo_pkg::acc_t           acc_q  [gpfo_pkg::ACC_STAGES];

  logic signed [PROD_W-1:0] prod_d [gpfo_pkg::BLADES];

  // Pick factors for left blade a and right blade a^LANE, fold the sign into
  // the left factor, multiply
  always_comb begin
    logic [gpfo_pkg::BLADE_BITS-1:0] bi;
    logic signed [COEFF_WIDTH-1:0]   l;
    logic signed [COEFF_WIDTH-1:0]   r;
    logic signed [COEFF_WIDTH:0]     ls;
    for (int a = 0; a < gpfo_pkg::BLADES; a++) begin
      bi = gpfo_pkg::BLADE_BITS'(a) ^ LANE_IDX;
      l  = cfg.on_left ? op[a] : x[a];
      r  = cfg.on_left ? x[bi] : op[bi];
      ls = (COEFF_WIDTH+1)'(l);
      if (gpfo_pkg::term_negative(gpfo_pkg::BLADE_BITS'(a), bi, cfg.neg_axes)) begin
        ls = -ls;
      end
      prod_d[a] = ls * r;
    end
  end

  // Accumulate in left-blade order, two terms per stage; carry the rest
  for (genvar s = 0; s < gpfo_pkg::ACC_STAGES; s++) begin : g_acc
    gpfo_pkg::acc_t prev;
    gpfo_pkg::acc_t part;

    always_comb begin
      prev = (s == 0) ? '0 : acc_q[(s == 0) ? 0 : s - 1];
      part = gpfo_pkg::sat_add(prev, gpfo_pkg::acc_t'(prod_q[s][2*s]));
    end

    always_ff @(posedge clk) begin
      if (load[s+1]) begin
        acc_q[s] <= gpfo_pkg::sat_add(part, gpfo_pkg::acc_t'(prod_q[s][2*s+1]));
      end
    end
  end

  // Product carry line
  always_ff @(posedge clk) begin
    if (load[0]) begin
      prod_q[0] <= prod_d;
    end
    for (int s = 1; s < gpfo_pkg::ACC_STAGES; s++) begin
      if (load[s]) begin
        prod_q[s] <= prod_q[s-1];
      end
    end
  end

  assign acc = acc_q[gpfo_pkg::ACC_STAGES-1];

endmodule

// ----- rtl/gpfo_merge.sv -----
// ----------------------------------------------------------------------------
// gpfo_merge
// Output stage: rounds each lane's sum to the coefficient format, clamps it,
// gathers the lane clamp flags into one overflow flag and registers the
// result transaction.
// ----------------------------------------------------------------------------
module gpfo_merge #(
  parameter int COEFF_WIDTH = 16
) (
  input  logic                               clk,
  input  logic                               load,
  input  gpfo_pkg::acc_t                     acc [gpfo_pkg::BLADES],
  input  logic                               last_in,
  output logic [gpfo_pkg::BLADES*COEFF_WIDTH-1:0] data,
  output logic                               ovf,
  output logic                               last
);

  localparam gpfo_pkg::acc_t HI = gpfo_pkg::acc_t'((64'd1 << (COEFF_WIDTH - 1)) - 64'd1);
  localparam gpfo_pkg::acc_t LO = -HI - gpfo_pkg::acc_t'(1);

  logic [gpfo_pkg::BLADES*COEFF_WIDTH-1:0] data_next;
  logic                                    ovf_next;

  // Round to nearest (ties up), shift down, clamp
  always_comb begin
    gpfo_pkg::acc_t q;
    ovf_next  = 1'b0;
    data_next = '0;
    for (int k = 0; k < gpfo_pkg::BLADES; k++) begin
      q = gpfo_pkg::sat_add(acc[k], gpfo_pkg::ROUND_HALF) >>> gpfo_pkg::FRAC_BITS;
      if (q > HI) begin
        q        = HI;
        ovf_next = 1'b1;
      end else if (q < LO) begin
        q        = LO;
        ovf_next = 1'b1;
      end
      data_next[k*COEFF_WIDTH +: COEFF_WIDTH] = q[COEFF_WIDTH-1:0];
    end
  end

  // Hold the result until the next stage advance
  always_ff @(posedge clk) begin
    if (load) begin
      data <= data_next;
      ovf  <= ovf_next;
      last <= last_in;
    end
  end

endmodule

// ----- rtl/geometric_product_fixed_operand.sv -----
// ----------------------------------------------------------------------------
// geometric_product_fixed_operand
// Streams multivector samples through a geometric product with a configured
// operand held in APB registers.
// ----------------------------------------------------------------------------
// Takes one sample per clock unless the output side stalls, and returns
// one product per sample. Eight blade lanes run side by side; each forms
// its eight products in one multiplier stage and folds them into a 64-bit
// saturating sum over four stages, then an output stage rounds, clamps and
// raises overflow. Every stage has its own valid bit, so bubbles close up
// and new samples are taken while a finished result waits. Registers (byte
// address): dimension (0x00), negative_axes (0x08), operand_on_left (0x10),
// operand_coeffs_low (0x18), operand_coeffs_high (0x20); change them only
// while nothing is in flight.
// ----------------------------------------------------------------------------
module geometric_product_fixed_operand #(
  parameter int COEFF_WIDTH = 16
) (
  input  logic                                    clk,
  input  logic                                    rst,
  // Sample stream
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  // tdata: x0, x1, x2, x3, x4, x5, x6, x7 (lowest bits first)
  input  logic [gpfo_pkg::BLADES*COEFF_WIDTH-1:0] s_axis_tdata,
  input  logic                                    s_axis_tlast,
  // Product stream
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  // tdata: y0, y1, y2, y3, y4, y5, y6, y7 (lowest bits first)
  output logic [gpfo_pkg::BLADES*COEFF_WIDTH-1:0] m_axis_tdata,
  // tuser: overflow
  output logic                                    m_axis_tuser,
  output logic                                    m_axis_tlast,
  // Configuration
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [gpfo_pkg::ADDR_W-1:0]             paddr,
  input  logic [gpfo_pkg::REG_W-1:0]              pwdata,
  output logic [gpfo_pkg::REG_W-1:0]              prdata,
  output logic                                    pready
);

  localparam int EXT_W = (4 * COEFF_WIDTH > gpfo_pkg::REG_W) ? 4 * COEFF_WIDTH
                                                             : gpfo_pkg::REG_W;
  localparam int NS = gpfo_pkg::PIPE_STAGES;

  // Configuration registers
  logic [1:0]                      dimension;
  logic [gpfo_pkg::BLADE_BITS-1:0] negative_axes;
  logic                            operand_on_left;
  logic [gpfo_pkg::REG_W-1:0]      operand_coeffs_low;
  logic [gpfo_pkg::REG_W-1:0]      operand_coeffs_high;

  logic       cfg_write;
  logic [2:0] reg_idx;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[5:3];
  assign cfg_write = psel && penable && pwrite && pready;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      dimension           <= 2'(gpfo_pkg::MAX_DIMENSION);
      negative_axes       <= '0;
      operand_on_left     <= 1'b0;
      operand_coeffs_low  <= '0;
      operand_coeffs_high <= '0;
    end else if (cfg_write) begin
      unique case (reg_idx)
        gpfo_pkg::REG_DIMENSION: dimension           <= pwdata[1:0];
        gpfo_pkg::REG_NEG_AXES:  negative_axes       <= pwdata[gpfo_pkg::BLADE_BITS-1:0];
        gpfo_pkg::REG_ON_LEFT:   operand_on_left     <= pwdata[0];
        gpfo_pkg::REG_OP_LOW:    operand_coeffs_low  <= pwdata;
        gpfo_pkg::REG_OP_HIGH:   operand_coeffs_high <= pwdata;
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (reg_idx)
      gpfo_pkg::REG_DIMENSION: prdata = gpfo_pkg::REG_W'(dimension);
      gpfo_pkg::REG_NEG_AXES:  prdata = gpfo_pkg::REG_W'(negative_axes);
      gpfo_pkg::REG_ON_LEFT:   prdata = gpfo_pkg::REG_W'(operand_on_left);
      gpfo_pkg::REG_OP_LOW:    prdata = operand_coeffs_low;
      gpfo_pkg::REG_OP_HIGH:   prdata = operand_coeffs_high;
      default:                 prdata = '0;
    endcase
  end

  // Active blades from the clamped dimension
  logic [1:0]                  dim_eff;
  logic [3:0]                  num_active;
  logic [gpfo_pkg::BLADES-1:0] active;

  always_comb begin
    dim_eff = dimension;
    if (dimension == 2'd0) begin
      dim_eff = 2'd1;
    end else if (dimension > 2'(gpfo_pkg::MAX_DIMENSION)) begin
      dim_eff = 2'(gpfo_pkg::MAX_DIMENSION);
    end
    num_active = 4'd1 << dim_eff;
    for (int k = 0; k < gpfo_pkg::BLADES; k++) begin
      active[k] = 4'(k) < num_active;
    end
  end

  // Unpack sample and operand coefficients; zero inactive blades
  logic [EXT_W-1:0]              op_ext_lo;
  logic [EXT_W-1:0]              op_ext_hi;
  logic signed [COEFF_WIDTH-1:0] x  [gpfo_pkg::BLADES];
  logic signed [COEFF_WIDTH-1:0] op [gpfo_pkg::BLADES];

  assign op_ext_lo = EXT_W'(operand_coeffs_low);
  assign op_ext_hi = EXT_W'(operand_coeffs_high);

  always_comb begin
    for (int k = 0; k < gpfo_pkg::BLADES; k++) begin
      x[k]  = active[k] ? s_axis_tdata[k*COEFF_WIDTH +: COEFF_WIDTH] : '0;
      if (k < 4) begin
        op[k] = active[k] ? op_ext_lo[k*COEFF_WIDTH +: COEFF_WIDTH] : '0;
      end else begin
        op[k] = active[k] ? op_ext_hi[(k-4)*COEFF_WIDTH +: COEFF_WIDTH] : '0;
      end
    end
  end

  // Stage occupancy and advance: a stage loads when empty or draining
  logic [NS-1:0] valid;
  logic [NS-1:0] ready;

  always_comb begin
    ready[NS-1] = !valid[NS-1] || m_axis_tready;
    for (int i = NS - 2; i >= 0; i--) begin
      ready[i] = !valid[i] || ready[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (ready[0]) begin
        valid[0] <= s_axis_tvalid;
      end
      for (int i = 1; i < NS; i++) begin
        if (ready[i]) begin
          valid[i] <= valid[i-1];
        end
      end
    end
  end

  assign s_axis_tready = ready[0];
  assign m_axis_tvalid = valid[NS-1];

  // Carry the batch marker alongside the lanes
  logic last_q [gpfo_pkg::LANE_STAGES];

  always_ff @(posedge clk) begin
    if (ready[0]) begin
      last_q[0] <= s_axis_tlast;
    end
    for (int i = 1; i < gpfo_pkg::LANE_STAGES; i++) begin
      if (ready[i]) begin
        last_q[i] <= last_q[i-1];
      end
    end
  end

  // Blade lanes
  gpfo_pkg::lane_cfg_t lane_cfg;
  gpfo_pkg::acc_t      lane_acc [gpfo_pkg::BLADES];

  assign lane_cfg.neg_axes = negative_axes;
  assign lane_cfg.on_left  = operand_on_left;

  for (genvar k = 0; k < gpfo_pkg::BLADES; k++) begin : g_lane
    gpfo_lane #(
      .COEFF_WIDTH (COEFF_WIDTH),
      .LANE        (k)
    ) u_lane (
      .clk  (clk),
      .load (ready[gpfo_pkg::LANE_STAGES-1:0]),
      .cfg  (lane_cfg),
      .x    (x),
      .op   (op),
      .acc  (lane_acc[k])
    );
  end

  // Round, clamp and register the result
  gpfo_merge #(
    .COEFF_WIDTH (COEFF_WIDTH)
  ) u_merge (
    .clk     (clk),
    .load    (ready[NS-1]),
    .acc     (lane_acc),
    .last_in (last_q[gpfo_pkg::LANE_STAGES-1]),
    .data    (m_axis_tdata),
    .ovf     (m_axis_tuser),
    .last    (m_axis_tlast)
  );

endmodule

// ----- rtl/gpfo_checker.sv -----
// ----------------------------------------------------------------------------
// gpfo_checker
// Port-level checks for the fixed-operand geometric product block, attached
// to the top level by a bind statement.
// ----------------------------------------------------------------------------
module gpfo_checker #(
  parameter int COEFF_WIDTH = 16
) (
  input logic                                    clk,
  input logic                                    rst,
  input logic                                    s_axis_tready,
  input logic                                    m_axis_tvalid,
  input logic                                    m_axis_tready,
  input logic [gpfo_pkg::BLADES*COEFF_WIDTH-1:0] m_axis_tdata,
  input logic                                    m_axis_tuser,
  input logic                                    m_axis_tlast,
  input logic                                    pready
);

  localparam logic [COEFF_WIDTH-1:0] RAIL_HI = {1'b0, {(COEFF_WIDTH-1){1'b1}}};
  localparam logic [COEFF_WIDTH-1:0] RAIL_LO = {1'b1, {(COEFF_WIDTH-1){1'b0}}};

  // True when some coefficient sits on a clamp rail
  function automatic logic on_rail(logic [gpfo_pkg::BLADES*COEFF_WIDTH-1:0] d);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < gpfo_pkg::BLADES; k++) begin
      hit = hit || (d[k*COEFF_WIDTH +: COEFF_WIDTH] == RAIL_HI)
                || (d[k*COEFF_WIDTH +: COEFF_WIDTH] == RAIL_LO);
    end
    on_rail = hit;
  endfunction

  // Pipeline comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // With the output stage empty, the whole pipeline can take a sample
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while output stage is empty");

  // A stalled result holds its payload
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // Overflow only with a coefficient clamped to a rail
  a_overflow_on_rail: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> on_rail(m_axis_tdata))
    else $error("overflow flag without a clamped coefficient");

  // Configuration port never waits
  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready dropped");

endmodule

bind geometric_product_fixed_operand gpfo_checker #(
  .COEFF_WIDTH (COEFF_WIDTH)
) u_gpfo_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast),
  .pready        (pready)
);

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams multivector samples through the fixed-operand geometric product
// block and compares every product, overflow flag and last marker against
// an independent model of the product. The operand, signature, dimension
// and operand side are written over APB between phases. The sample and
// product sides idle and stall at random, and one phase holds the product
// side off long enough to back up the pipeline.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CW          = 16;
  localparam int DATA_W      = gpfo_pkg::BLADES * CW;
  localparam int STALL_LIMIT = 2000;
  localparam longint COEFF_MAX = (64'sd1 <<< (CW - 1)) - 1;
  localparam longint COEFF_MIN = -COEFF_MAX - 1;
  localparam longint HALF_LSB  = 64'sd1 <<< (gpfo_pkg::FRAC_BITS - 1);

  typedef struct packed {
    logic              last;
    logic              overflow;
    logic [DATA_W-1:0] coeffs;
  } product_t;

  logic                        clk;
  logic                        rst           = 1'b1;
  logic                        s_axis_tvalid = 1'b0;
  logic                        s_axis_tready;
  // tdata: x0, x1, x2, x3, x4, x5, x6, x7 (lowest bits first)
  logic [DATA_W-1:0]           s_axis_tdata  = '0;
  logic                        s_axis_tlast  = 1'b0;
  logic                        m_axis_tvalid;
  logic                        m_axis_tready = 1'b0;
  // tdata: y0, y1, y2, y3, y4, y5, y6, y7 (lowest bits first)
  logic [DATA_W-1:0]           m_axis_tdata;
  // tuser: overflow
  logic                        m_axis_tuser;
  logic                        m_axis_tlast;
  logic                        psel          = 1'b0;
  logic                        penable       = 1'b0;
  logic                        pwrite        = 1'b0;
  logic [gpfo_pkg::ADDR_W-1:0] paddr         = '0;
  logic [gpfo_pkg::REG_W-1:0]  pwdata        = '0;
  logic [gpfo_pkg::REG_W-1:0]  prdata;
  logic                        pready;

  // Register contents as the block should hold them
  logic [1:0]  cfg_dimension = 2'd3;
  logic [2:0]  cfg_neg_axes  = 3'd0;
  logic        cfg_on_left   = 1'b0;
  logic [63:0] cfg_op_low    = '0;
  logic [63:0] cfg_op_high   = '0;

  product_t pending_products[$];
  int       mismatch_count = 0;
  int       send_idle_pct  = 0;
  int       recv_stall_pct = 0;
  logic     hold_output    = 1'b0;
  int       quiet_cycles   = 0;

  geometric_product_fixed_operand #(
    .COEFF_WIDTH(CW)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Odd number of swaps when blade a is moved past blade b, plus one per
  // shared axis that squares to -1
  function automatic logic blade_sign_flips(logic [2:0] a, logic [2:0] b, logic [2:0] neg);
    int swaps;
    swaps = 0;
    for (int i = 0; i < gpfo_pkg::BLADE_BITS; i++) begin
      if (a[i]) begin
        for (int j = 0; j < i; j++) swaps += b[j];
        if (b[i] && neg[i]) swaps++;
      end
    end
    return swaps[0];
  endfunction

  // Geometric product of one sample with the configured operand
  function automatic product_t geometric_product(logic [DATA_W-1:0] sample, logic last);
    longint   smp [gpfo_pkg::BLADES];
    longint   opd [gpfo_pkg::BLADES];
    longint   sum [gpfo_pkg::BLADES];
    longint   lft, rgt, q;
    int       active;
    product_t res;
    active = (cfg_dimension == 2'd0) ? 2 : (1 << cfg_dimension);
    for (int k = 0; k < gpfo_pkg::BLADES; k++) begin
      smp[k] = 0;
      opd[k] = 0;
      sum[k] = 0;
      if (k < active) begin
        smp[k] = $signed(sample[k*CW +: CW]);
        if (k < 4) opd[k] = $signed(cfg_op_low[k*CW +: CW]);
        else opd[k] = $signed(cfg_op_high[(k-4)*CW +: CW]);
      end
    end
    for (int a = 0; a < active; a++) begin
      for (int b = 0; b < active; b++) begin
        lft = cfg_on_left ? opd[a] : smp[a];
        rgt = cfg_on_left ? smp[b] : opd[b];
        if (blade_sign_flips(3'(a), 3'(b), cfg_neg_axes)) sum[a ^ b] -= lft * rgt;
        else sum[a ^ b] += lft * rgt;
      end
    end
    res.last     = last;
    res.overflow = 1'b0;
    res.coeffs   = '0;
    // Round half up, then clamp to the coefficient range
    for (int k = 0; k < active; k++) begin
      q = (sum[k] + HALF_LSB) >>> gpfo_pkg::FRAC_BITS;
      if (q > COEFF_MAX) begin
        q = COEFF_MAX;
        res.overflow = 1'b1;
      end else if (q < COEFF_MIN) begin
        q = COEFF_MIN;
        res.overflow = 1'b1;
      end
      res.coeffs[k*CW +: CW] = q[CW-1:0];
    end
    return res;
  endfunction

  // Mix of small values, full-range values and corner values
  function automatic logic [DATA_W-1:0] random_vector();
    logic [DATA_W-1:0] vec;
    int                style;
    style = $urandom_range(9);
    for (int k = 0; k < gpfo_pkg::BLADES; k++) begin
      if (style < 5) begin
        vec[k*CW +: CW] = CW'($urandom_range(4095)) - CW'(2048);
      end else if (style < 8) begin
        vec[k*CW +: CW] = CW'($urandom);
      end else begin
        case ($urandom_range(3))
          0: vec[k*CW +: CW] = 16'h7FFF;
          1: vec[k*CW +: CW] = 16'h8000;
          2: vec[k*CW +: CW] = 16'hFFFF;
          default: vec[k*CW +: CW] = CW'($urandom);
        endcase
      end
    end
    return vec;
  endfunction

  function automatic logic [DATA_W-1:0] splat(logic [CW-1:0] value);
    return {gpfo_pkg::BLADES{value}};
  endfunction

  task automatic set_idling(input int send_pct, input int stall_pct);
    send_idle_pct = send_pct;
    recv_stall_pct <= stall_pct;
  endtask

  // Offer one sample; valid stays high on return so a following sample
  // can go out back to back
  task automatic send_sample(input logic [DATA_W-1:0] sample, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= sample;
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    pending_products.push_back(geometric_product(sample, last));
  endtask

  // Drop valid, wait for every product, then let the pipeline settle
  task automatic drain_products();
    s_axis_tvalid <= 1'b0;
    while (pending_products.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Setup and access cycle of one write; the caller releases the bus
  task automatic write_register(input logic [2:0] index, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (index)
      gpfo_pkg::REG_DIMENSION: cfg_dimension = value[1:0];
      gpfo_pkg::REG_NEG_AXES:  cfg_neg_axes  = value[2:0];
      gpfo_pkg::REG_ON_LEFT:   cfg_on_left   = value[0];
      gpfo_pkg::REG_OP_LOW:    cfg_op_low    = value;
      gpfo_pkg::REG_OP_HIGH:   cfg_op_high   = value;
      default: ;
    endcase
  endtask

  task automatic configure(input logic [1:0] dim, input logic [2:0] neg, input logic left,
                           input logic [63:0] low, input logic [63:0] high);
    write_register(gpfo_pkg::REG_DIMENSION, {62'd0, dim});
    write_register(gpfo_pkg::REG_NEG_AXES, {61'd0, neg});
    write_register(gpfo_pkg::REG_ON_LEFT, {63'd0, left});
    write_register(gpfo_pkg::REG_OP_LOW, low);
    write_register(gpfo_pkg::REG_OP_HIGH, high);
    // Release the bus
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Reset operand is zero, so every product comes out zero
  task automatic test_reset_state();
    set_idling(0, 0);
    send_sample(splat(16'h7FFF), 1'b0);
    send_sample(splat(16'h8000), 1'b1);
    send_sample(random_vector(), 1'b0);
    send_sample(random_vector(), 1'b1);
    drain_products();
  endtask

  task automatic test_directed_cases();
    // Half-scale scalar operand: rounding ties both ways and full-scale samples
    configure(2'd3, 3'd0, 1'b0, {48'd0, 16'h0800}, 64'd0);
    send_sample(splat(16'h0001), 1'b0);
    send_sample(splat(16'hFFFF), 1'b1);
    send_sample(splat(16'h7FFF), 1'b0);
    send_sample(splat(16'h8000), 1'b1);
    drain_products();
    // Full-scale operand on the left, every axis negative: saturation
    configure(2'd3, 3'd7, 1'b1, {4{16'h7FFF}}, {4{16'h8000}});
    send_sample(splat(16'h7FFF), 1'b0);
    send_sample(splat(16'h8000), 1'b1);
    send_sample({4{16'h8000, 16'h7FFF}}, 1'b0);
    send_sample('0, 1'b1);
    drain_products();
    // Mixed signature with the sample on the left
    configure(2'd3, 3'b011, 1'b0, {16'h0400, 16'hF800, 16'h1000, 16'h0C00},
              {16'hE000, 16'h0200, 16'h1800, 16'hFC00});
    repeat (3) send_sample(random_vector(), 1'b0);
    drain_products();
    // Dimension zero acts as one axis; signature bits above it are ignored
    configure(2'd0, 3'b110, 1'b0, {4{16'h1000}}, {4{16'h1000}});
    send_sample(splat(16'h1234), 1'b1);
    repeat (2) send_sample(random_vector(), 1'b0);
    drain_products();
    // Two axes with the operand on the left; upper operand blades inactive
    configure(2'd2, 3'b101, 1'b1, {4{16'hC000}}, {16'h3000, 16'h2000, 16'h1000, 16'h0800});
    repeat (3) send_sample(random_vector(), 1'b1);
    drain_products();
    // One negative axis
    configure(2'd1, 3'b001, 1'b0, {32'd0, 16'h2000, 16'hE000}, 64'd0);
    repeat (2) send_sample(random_vector(), 1'b0);
    drain_products();
  endtask

  task automatic test_random_phases();
    logic [DATA_W-1:0] opnd;
    for (int phase = 0; phase < 10; phase++) begin
      case (phase % 4)
        0: set_idling(0, 0);
        1: set_idling(68, 0);
        2: set_idling(0, 68);
        default: set_idling(38, 38);
      endcase
      opnd = random_vector();
      if (phase == 0) configure(2'd3, 3'd7, 1'b1, {4{16'h8000}}, {4{16'h7FFF}});
      else if (phase == 9) configure(2'd0, 3'd0, 1'b0, {4{16'h7FFF}}, {4{16'h8000}});
      else configure(2'($urandom_range(3)), 3'($urandom_range(7)), 1'($urandom_range(1)),
                     opnd[63:0], opnd[127:64]);
      repeat (105) send_sample(random_vector(), $urandom_range(7) == 0);
      drain_products();
    end
  endtask

  // Hold the product side off while samples keep coming, so the block fills
  task automatic test_backpressure();
    logic [DATA_W-1:0] opnd;
    set_idling(0, 0);
    opnd = random_vector();
    configure(2'd3, 3'b010, 1'b0, opnd[63:0], opnd[127:64]);
    hold_output <= 1'b1;
    fork
      begin
        repeat (80) @(posedge clk);
        hold_output <= 1'b0;
      end
    join_none
    repeat (40) send_sample(random_vector(), 1'($urandom_range(1)));
    drain_products();
  endtask

  // Product side ready, with random stalls and the long hold
  always @(posedge clk) begin
    if (rst || hold_output) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each product transaction with the oldest expectation
  always @(posedge clk) begin : product_check
    product_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_products.size() == 0) begin
        $display("%0t: product with none expected: data %h overflow %b last %b",
                 $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
        mismatch_count++;
      end else begin
        want = pending_products.pop_front();
        for (int k = 0; k < gpfo_pkg::BLADES; k++) begin
          if (m_axis_tdata[k*CW +: CW] !== want.coeffs[k*CW +: CW]) begin
            $display("%0t: y%0d expected %h actual %h", $time, k,
                     want.coeffs[k*CW +: CW], m_axis_tdata[k*CW +: CW]);
            mismatch_count++;
          end
        end
        if (m_axis_tuser !== want.overflow) begin
          $display("%0t: overflow expected %b actual %b", $time, want.overflow, m_axis_tuser);
          mismatch_count++;
        end
        if (m_axis_tlast !== want.last) begin
          $display("%0t: last expected %b actual %b", $time, want.last, m_axis_tlast);
          mismatch_count++;
        end
      end
    end
  end

  // End the run when no transaction has moved for too long
  always @(posedge clk) begin
    if (rst || psel || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_directed_cases();
    test_random_phases();
    test_backpressure();
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
